/* rtl/core/b3sd_pkg.sv */
package b3sd_pkg;

   // Image geometry limits.
   localparam int MAX_WIDTH = 128;
   localparam int MAX_ROWS  = 1024;
   localparam int MIN_DIM   = 3;

   // Field and counter widths.
   localparam int PIX_W   = 5;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int RW_W    = 8;
   localparam int FR_W    = 11;
   localparam int LVL_W   = 5;
   localparam int SUM_W   = 9;
   localparam int THR_W   = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // Window size of the box filter.
   localparam int NINE = 9;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_ROW_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_ROWS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STAR_LEVEL = 2'd2;

   // Register reset values.
   localparam logic [RW_W-1:0]  ROW_WIDTH_RST  = 8'd80;
   localparam logic [FR_W-1:0]  FRAME_ROWS_RST = 11'd20;
   localparam logic [LVL_W-1:0] STAR_LEVEL_RST = 5'd10;

   // One line store word: the line two above and the line above.
   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
   } line_word_type;

   // Write side of the line store.
   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
      line_word_type    data;
   } line_wr_type;

endpackage

/* rtl/core/b3sd_channels.sv */
interface b3sd_req_if;
   import b3sd_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;
   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface b3sd_rsp_if;
   logic valid;
   logic ready;
   logic star;
   logic end_of_row;
   logic end_of_frame;
   modport source (output valid, output star, output end_of_row, output end_of_frame,
                   input ready);
   modport sink   (input valid, input star, input end_of_row, input end_of_frame,
                   output ready);
endinterface

interface b3sd_csr_if;
   import b3sd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/b3sd_line_ram.sv */
module b3sd_line_ram (
   input  logic                    clock,
   input  b3sd_pkg::line_wr_type   wr,
   input  logic [b3sd_pkg::COL_W-1:0] rd_addr,
   output b3sd_pkg::line_word_type rd_data
);
   import b3sd_pkg::*;

   line_word_type mem [MAX_WIDTH];
   line_word_type rd_data_ff;

   // Both line stores share one word per column.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Registered read.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/box3x3_star_detect_top.sv */
// The result word for a centre pixel enters the output register as the pixel below and to
// the right of it is accepted. Throughput: one pixel word per cycle unless the output
// stalls; the line store reads the next column ahead.
// Reset clears the counters, the window and the output valid flag and restores the
// register defaults; line store contents stay undefined until written.
module box3x3_star_detect_top (
   input  logic clock,
   input  logic reset,
   b3sd_req_if.sink   req,
   b3sd_rsp_if.source rsp,
   b3sd_csr_if.sink   csr
);
   import b3sd_pkg::*;

   logic [RW_W-1:0]  row_width_ff;
   logic [FR_W-1:0]  frame_rows_ff;
   logic [LVL_W-1:0] star_level_ff;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [PIX_W-1:0] win_ff [6];

   logic rsp_valid_ff, rsp_valid_in;
   logic star_ff, eor_ff, eof_ff;

   logic [RW_W-1:0]  w_eff;
   logic [FR_W-1:0]  h_eff;
   logic             accept;
   logic             interior;
   logic             last_col;
   logic             last_row;
   logic [SUM_W-1:0] sum;
   logic [THR_W-1:0] thr;
   logic             is_star;

   line_wr_type      wr;
   line_word_type    rd_data;
   logic [COL_W-1:0] rd_addr;

   // Configuration writes; indexes beyond the list are ignored.
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff  <= ROW_WIDTH_RST;
         frame_rows_ff <= FRAME_ROWS_RST;
         star_level_ff <= STAR_LEVEL_RST;
      end else if (csr.valid) begin
         case (csr.index)
            REG_ROW_WIDTH:  row_width_ff  <= csr.data[RW_W-1:0];
            REG_FRAME_ROWS: frame_rows_ff <= csr.data[FR_W-1:0];
            REG_STAR_LEVEL: star_level_ff <= csr.data[LVL_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the geometry to the supported range.
   always_comb begin
      if (row_width_ff < RW_W'(MIN_DIM)) begin
         w_eff = RW_W'(MIN_DIM);
      end else if (row_width_ff > RW_W'(MAX_WIDTH)) begin
         w_eff = RW_W'(MAX_WIDTH);
      end else begin
         w_eff = row_width_ff;
      end
      if (frame_rows_ff < FR_W'(MIN_DIM)) begin
         h_eff = FR_W'(MIN_DIM);
      end else if (frame_rows_ff > FR_W'(MAX_ROWS)) begin
         h_eff = FR_W'(MAX_ROWS);
      end else begin
         h_eff = frame_rows_ff;
      end
   end

   // A pixel word enters whenever the output register is free or being drained.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign interior = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
   assign last_col = (RW_W'(col_ff) + RW_W'(1)) >= w_eff;
   assign last_row = (FR_W'(row_ff) + FR_W'(1)) >= h_eff;

   // Box sum of the nine values; mean above level means sum at least 9 * (level + 1).
   assign sum = SUM_W'(win_ff[0]) + SUM_W'(win_ff[1]) + SUM_W'(win_ff[2])
              + SUM_W'(win_ff[3]) + SUM_W'(win_ff[4]) + SUM_W'(win_ff[5])
              + SUM_W'(rd_data.top) + SUM_W'(rd_data.mid) + SUM_W'(req.pixel);
   assign thr     = THR_W'(star_level_ff) * THR_W'(NINE) + THR_W'(NINE);
   assign is_star = THR_W'(sum) >= thr;

   // Raster counters.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Shift the window by one column per accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (accept) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= rd_data.top;
         win_ff[4] <= rd_data.mid;
         win_ff[5] <= req.pixel;
      end
   end

   // The read always targets the column of the next word, so its data is ready in time.
   // The write goes to the current column, which never equals the next one.
   assign rd_addr      = reset ? '0 : col_in;
   assign wr.en        = accept;
   assign wr.addr      = col_ff;
   assign wr.data.top  = rd_data.mid;
   assign wr.data.mid  = req.pixel;

   b3sd_line_ram u_line_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = interior;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && interior) begin
         star_ff <= is_star;
         eor_ff  <= last_col;
         eof_ff  <= last_col && last_row;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.star         = star_ff;
   assign rsp.end_of_row   = eor_ff;
   assign rsp.end_of_frame = eof_ff;

endmodule

/* verif/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import b3sd_pkg::*;

   localparam int CLOCK_HALF    = 2;
   localparam int RESET_CYCLES  = 5;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int TAIL_CYCLES   = 8;
   localparam int RANDOM_PIXELS = 700;
   localparam int RUN_LIMIT     = 2000000;

   // Index past the end of the register list; writes to it must be ignored.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   typedef enum int {MIX_FULL, MIX_RANGE, MIX_SPARSE, MIX_BRIGHT} pixel_mix_type;
   typedef enum int {STALL_NONE, STALL_COIN, STALL_RUNS, STALL_BLIPS} stall_style_type;

   typedef struct packed {
      logic star;
      logic end_of_row;
      logic end_of_frame;
   } star_word_type;

   logic clock = 1'b0;
   logic reset;

   b3sd_req_if req_ch ();
   b3sd_rsp_if rsp_ch ();
   b3sd_csr_if csr_ch ();

   box3x3_star_detect_top u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // Shadow copy of the detector: configuration, line stores, window and counters.
   logic [RW_W-1:0]  cfg_width;
   logic [FR_W-1:0]  cfg_rows;
   logic [LVL_W-1:0] cfg_level;
   logic [PIX_W-1:0] line_up     [MAX_WIDTH];
   logic [PIX_W-1:0] line_two_up [MAX_WIDTH];
   logic [PIX_W-1:0] win         [6];
   int               col_pos;
   int               row_pos;

   star_word_type expected_stars [$];
   int            mismatches   = 0;
   int            results_seen = 0;
   int            pixels_sent  = 0;
   int            burst_left   = 0;
   bit            sender_gaps  = 1'b1;

   function automatic int clamp_dim(input int value, input int upper);
      if (value < MIN_DIM) return MIN_DIM;
      if (value > upper) return upper;
      return value;
   endfunction

   task automatic reset_predictor();
      cfg_width = ROW_WIDTH_RST;
      cfg_rows  = FRAME_ROWS_RST;
      cfg_level = STAR_LEVEL_RST;
      foreach (line_up[i]) begin
         line_up[i]     = '0;
         line_two_up[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
   endtask

   // Advance the shadow state by one pixel and queue the star word it produces, if any.
   task automatic predict_star(input logic [PIX_W-1:0] px);
      int               w;
      int               h;
      int               box_sum;
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      star_word_type    want;
      w   = clamp_dim(int'(cfg_width), MAX_WIDTH);
      h   = clamp_dim(int'(cfg_rows), MAX_ROWS);
      top = line_two_up[col_pos];
      mid = line_up[col_pos];
      if (row_pos >= 2 && col_pos >= 2) begin
         box_sum = int'(px) + int'(top) + int'(mid);
         foreach (win[i]) box_sum += int'(win[i]);
         want.star         = (box_sum / NINE) > int'(cfg_level);
         want.end_of_row   = (col_pos + 1 >= w);
         want.end_of_frame = (col_pos + 1 >= w) && (row_pos + 1 >= h);
         expected_stars.push_back(want);
      end
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = px;
      line_two_up[col_pos] = mid;
      line_up[col_pos]     = px;
      // A counter at or past the last index wraps on this advance.
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endtask

   function automatic logic [PIX_W-1:0] pick_pixel(input pixel_mix_type mix);
      case (mix)
         MIX_RANGE:  return PIX_W'($urandom_range(0, 20));
         MIX_SPARSE: return ($urandom_range(0, 15) == 0) ? PIX_W'(31 - $urandom_range(0, 3))
                                                         : PIX_W'($urandom_range(0, 4));
         MIX_BRIGHT: return PIX_W'($urandom_range(18, 31));
         default:    return PIX_W'($urandom_range(0, 31));
      endcase
   endfunction

   // Send one pixel word; bursts of random length are separated by random gaps.
   task automatic send_pixel(input logic [PIX_W-1:0] px);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = sender_gaps ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.pixel <= px;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
      pixels_sent++;
      predict_star(px);
   endtask

   task automatic send_pixels(input int count, input pixel_mix_type mix);
      repeat (count) send_pixel(pick_pixel(mix));
   endtask

   // Send until the frame counters are back at the first pixel of a frame.
   task automatic send_frame_rest(input pixel_mix_type mix);
      do send_pixel(pick_pixel(mix));
      while (col_pos != 0 || row_pos != 0);
   endtask

   // Stop sending and wait until every expected word is in, plus the output latency.
   task automatic drain_stars();
      int waited;
      @(negedge clock);
      req_ch.valid <= 1'b0;
      waited = 0;
      while (expected_stars.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         REG_ROW_WIDTH:  cfg_width = value[RW_W-1:0];
         REG_FRAME_ROWS: cfg_rows  = value[FR_W-1:0];
         REG_STAR_LEVEL: cfg_level = value[LVL_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Three rows at the default geometry and level, leaving the frame open.
   task automatic test_reset_values();
      send_pixels(3 * ROW_WIDTH_RST, MIX_RANGE);
   endtask

   task automatic test_directed();
      drain_stars();
      // Shrink the geometry below its minimum in the middle of the open frame;
      // the row counter is then past the new last row and wraps at the row end.
      write_reg(REG_ROW_WIDTH, '0);
      write_reg(REG_FRAME_ROWS, CSR_DATA_W'(2));
      write_reg(REG_STAR_LEVEL, '0);
      send_frame_rest(MIX_RANGE);
      // Brightest pixels everywhere; the spare register write must not touch the level.
      drain_stars();
      write_reg(REG_STAR_LEVEL, CSR_DATA_W'(20));
      write_reg(REG_SPARE, '1);
      repeat (9) send_pixel(PIX_W'(31));
      // Sum of 98 gives a mean equal to the level, so no star.
      drain_stars();
      write_reg(REG_STAR_LEVEL, CSR_DATA_W'(10));
      repeat (8) send_pixel(PIX_W'(11));
      send_pixel(PIX_W'(10));
      // Sum of 99 gives a mean one above the level.
      repeat (4) send_pixel(PIX_W'(20));
      send_pixel(PIX_W'(19));
      repeat (4) send_pixel(PIX_W'(0));
   endtask

   task automatic test_width_limits();
      drain_stars();
      write_reg(REG_ROW_WIDTH, CSR_DATA_W'(MAX_WIDTH));
      write_reg(REG_FRAME_ROWS, CSR_DATA_W'(3));
      write_reg(REG_STAR_LEVEL, CSR_DATA_W'(8));
      send_frame_rest(MIX_FULL);
      // Width above the maximum, and the upper data bits set; height below the minimum.
      drain_stars();
      write_reg(REG_ROW_WIDTH, '1);
      write_reg(REG_FRAME_ROWS, '0);
      write_reg(REG_STAR_LEVEL, CSR_DATA_W'(2));
      send_frame_rest(MIX_SPARSE);
   endtask

   task automatic test_tall_frame();
      drain_stars();
      write_reg(REG_ROW_WIDTH, CSR_DATA_W'(3));
      write_reg(REG_STAR_LEVEL, CSR_DATA_W'(15));
      // Height above the maximum, then cut short in the middle of the frame.
      write_reg(REG_FRAME_ROWS, '1);
      send_pixels(36, MIX_BRIGHT);
      drain_stars();
      write_reg(REG_FRAME_ROWS, CSR_DATA_W'(5));
      send_frame_rest(MIX_BRIGHT);
   endtask

   task automatic test_level_limits();
      drain_stars();
      write_reg(REG_ROW_WIDTH, CSR_DATA_W'(5));
      write_reg(REG_FRAME_ROWS, CSR_DATA_W'(4));
      write_reg(REG_STAR_LEVEL, '1);
      send_frame_rest(MIX_BRIGHT);
      drain_stars();
      write_reg(REG_STAR_LEVEL, '0);
      send_frame_rest(MIX_SPARSE);
   endtask

   // Random frames, mostly small; some get a register change part way through.
   task automatic test_random_frames();
      int                    start_count;
      int                    w_pick;
      int                    h_pick;
      int                    eff_w;
      int                    part;
      logic [CSR_DATA_W-1:0] value;
      pixel_mix_type         mix;
      start_count = pixels_sent;
      while (pixels_sent - start_count < RANDOM_PIXELS) begin
         drain_stars();
         sender_gaps = ($urandom_range(0, 3) != 0);
         mix = pixel_mix_type'($urandom_range(0, 3));
         case ($urandom_range(0, 19))
            0:          w_pick = $urandom_range(0, 2);
            1:          w_pick = $urandom_range(129, 255);
            2, 3:       w_pick = $urandom_range(100, 128);
            4, 5, 6, 7: w_pick = $urandom_range(11, 40);
            default:    w_pick = $urandom_range(3, 10);
         endcase
         if (w_pick > 40) h_pick = $urandom_range(0, 4);
         else if ($urandom_range(0, 9) == 0) h_pick = $urandom_range(0, 2);
         else h_pick = $urandom_range(3, 9);
         value = CSR_DATA_W'($urandom);
         value[RW_W-1:0] = RW_W'(w_pick);
         write_reg(REG_ROW_WIDTH, value);
         write_reg(REG_FRAME_ROWS, CSR_DATA_W'(h_pick));
         value = CSR_DATA_W'($urandom);
         value[LVL_W-1:0] = ($urandom_range(0, 4) == 0) ? LVL_W'($urandom_range(0, 31))
                                                        : LVL_W'($urandom_range(0, 20));
         write_reg(REG_STAR_LEVEL, value);
         if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, CSR_DATA_W'($urandom));
         if ($urandom_range(0, 3) == 0) begin
            // The width may only shrink inside a frame, so no unwritten column is read.
            eff_w = clamp_dim(int'(cfg_width), MAX_WIDTH);
            part  = $urandom_range(1, eff_w * clamp_dim(int'(cfg_rows), MAX_ROWS) - 1);
            send_pixels(part, mix);
            drain_stars();
            case ($urandom_range(0, 2))
               0:       write_reg(REG_STAR_LEVEL, CSR_DATA_W'($urandom_range(0, 31)));
               1:       write_reg(REG_FRAME_ROWS, CSR_DATA_W'($urandom_range(0, 9)));
               default: write_reg(REG_ROW_WIDTH, CSR_DATA_W'($urandom_range(0, eff_w)));
            endcase
         end
         send_frame_rest(mix);
      end
   endtask

   // Receiver: ready follows a style that is picked anew at random.
   initial begin
      stall_style_type style;
      int              style_left;
      int              run_left;
      logic            hold;
      rsp_ch.ready = 1'b0;
      style      = STALL_NONE;
      style_left = 0;
      run_left   = 0;
      hold       = 1'b1;
      forever begin
         @(negedge clock);
         if (style_left == 0) begin
            style      = stall_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(100, 400);
         end
         style_left--;
         case (style)
            STALL_NONE: rsp_ch.ready <= 1'b1;
            STALL_COIN: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
            STALL_RUNS: begin
               if (run_left == 0) begin
                  hold     = !hold;
                  run_left = hold ? $urandom_range(1, 12) : $urandom_range(1, 16);
               end
               run_left--;
               rsp_ch.ready <= hold;
            end
            default: rsp_ch.ready <= ($urandom_range(0, 5) != 0);
         endcase
      end
   end

   // Compare each accepted result word with the oldest expected one.
   always @(posedge clock) begin
      star_word_type seen;
      star_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen = {rsp_ch.star, rsp_ch.end_of_row, rsp_ch.end_of_frame};
         if (expected_stars.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d unexpected: star=%b end_of_row=%b end_of_frame=%b",
                        results_seen, seen.star, seen.end_of_row, seen.end_of_frame);
         end else begin
            want = expected_stars.pop_front();
            if (seen.star !== want.star || seen.end_of_row !== want.end_of_row ||
                seen.end_of_frame !== want.end_of_frame) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected star=%b end_of_row=%b end_of_frame=%b, %s%b %s%b %s%b",
                           results_seen, want.star, want.end_of_row, want.end_of_frame,
                           "got star=", seen.star, "end_of_row=", seen.end_of_row,
                           "end_of_frame=", seen.end_of_frame);
            end
         end
         results_seen++;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.pixel = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_ROW_WIDTH;
      csr_ch.data  = '0;
      reset        = 1'b1;
      reset_predictor();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_directed();
      test_width_limits();
      test_tall_frame();
      test_level_limits();
      test_random_frames();

      drain_stars();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_stars.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         if (expected_stars.size() != 0)
            $display("%0d expected result words never arrived", expected_stars.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #RUN_LIMIT;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

/* box3x3_star_detect_top.f */
rtl/core/b3sd_pkg.sv
rtl/core/b3sd_channels.sv
rtl/core/b3sd_line_ram.sv
rtl/core/box3x3_star_detect_top.sv
verif/testbench.sv
